### sv/tsrt_pkg.sv
// ----------------------------------------------------------------------------
// tsrt_pkg: shared types for the timestamp sorted record table
// constants, request and result structs, cell records and codes
// ----------------------------------------------------------------------------
package tsrt_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_RANK  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // packed month first so a plain unsigned compare orders by time
  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } stamp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] quantity;
    stamp_t      stamp;
  } rec_t;

  typedef struct packed {
    logic occ;
    rec_t rec;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] target_id;
    logic [5:0]  rank;
    logic [15:0] quantity;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] record_id;
    logic [15:0] record_quantity;
    logic [3:0]  record_month;
    logic [4:0]  record_day;
    logic [4:0]  record_hour;
    logic [5:0]  record_minute;
    logic [5:0]  record_second;
    logic [6:0]  entry_count;
  } res_t;

endpackage

### sv/tsrt_cell.sv
// ----------------------------------------------------------------------------
// tsrt_cell: one slot of the sorted record chain
// holds a record, flags it against the request, shifts with its neighbors
// ----------------------------------------------------------------------------
module tsrt_cell import tsrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cap_i,
  input  logic [31:0] tgt_id_i,
  input  stamp_t      new_stamp_i,
  input  cell_ctl_t   ctl_i,
  input  logic        prev_gt_i,
  input  logic        del_i,
  input  slot_t       prev_slot_i,
  input  slot_t       next_slot_i,
  input  rec_t        new_rec_i,
  output slot_t       slot_o,
  output logic        gt_o,
  output logic        match_o
);

  logic  occ_q, occ_d;
  rec_t  rec_q, rec_d;
  logic  gt_q, match_q;

  always_comb begin
    occ_d = occ_q;
    rec_d = rec_q;
    if (ctl_i.ins && !gt_q) begin
      if (prev_gt_i) begin
        // insert point: first slot not newer than the new stamp
        occ_d = 1'b1;
        rec_d = new_rec_i;
      end else begin
        occ_d = prev_slot_i.occ;
        rec_d = prev_slot_i.rec;
      end
    end else if (ctl_i.rem && del_i) begin
      occ_d = next_slot_i.occ;
      rec_d = next_slot_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (cap_i) begin
        gt_q    <= occ_q && (rec_q.stamp > new_stamp_i);
        match_q <= occ_q && (rec_q.id == tgt_id_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign slot_o  = '{occ: occ_q, rec: rec_q};
  assign gt_o    = gt_q;
  assign match_o = match_q;

endmodule

### sv/timestamp_sorted_record_table_unit.sv
// ----------------------------------------------------------------------------
// timestamp_sorted_record_table_unit: newest-first record table
// insert by timestamp, remove by id, read by rank, over a chain of cells
// ----------------------------------------------------------------------------
// A request passes through the idle and exec states: busy is high in the
// cycle after the accept and low again in the cycle that carries the result,
// so no new request is taken until the last one is through. In the accept
// cycle every cell compares its record with the request (stamp newer,
// id match) and registers the flags; in the exec state the whole chain
// shifts by one slot in one step, the count updates and the result is
// registered. result_valid_o is high for exactly one cycle per request and
// cannot be held off, so the receiver must take it when it appears. The
// table holds DEPTH records (64); an insert into a full table returns
// status full and uses no id, a remove of an unknown id returns not found,
// and a read at a rank not below the count returns rank beyond count.
// The year is not part of the order; equal stamps keep the newest insert
// first. Writing the configuration register sets the id of the next insert.
// ----------------------------------------------------------------------------
module timestamp_sorted_record_table_unit import tsrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        result_valid_o,
  output res_t        result_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  // control
  state_e            state_q, state_d;
  logic              accept;
  logic              exec;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [31:0]       next_id_q;
  req_t              req_q;
  logic [DEPTH-1:0]  rank_hit_q;
  logic              res_valid_q;
  res_t              res_q, res_d;

  // cell chain
  slot_t             slot   [DEPTH];
  logic [DEPTH-1:0]  gt_vec;
  logic [DEPTH-1:0]  match_vec;
  logic [DEPTH-1:0]  del_vec;
  logic [DEPTH-1:0]  first_vec;
  logic [DEPTH-1:0]  occ_vec;
  cell_ctl_t         ctl;
  stamp_t            in_stamp;
  stamp_t            req_stamp;
  rec_t              new_rec;

  // selected records
  rec_t              rem_rec;
  rec_t              rd_rec;
  logic              found;
  logic              full;
  logic              bad_rank;

  assign accept = start && !busy;

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      res_valid_q <= 1'b0;
      rank_hit_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= exec;
      if (cfg_we_i) begin
        next_id_q <= cfg_wdata_i;
      end else if (ctl.ins) begin
        next_id_q <= next_id_q + 32'd1;
      end
      if (accept) begin
        for (int i = 0; i < DEPTH; i++) begin
          rank_hit_q[i] <= (32'(req_i.rank) == 32'(i));
        end
      end
    end
  end

  // request payload and result register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    res_q <= res_d;
  end

  // ---------------------------------------------------------------- chain
  assign in_stamp  = '{month: req_i.month, day: req_i.day, hour: req_i.hour,
                       minute: req_i.minute, second: req_i.second};
  assign req_stamp = '{month: req_q.month, day: req_q.day, hour: req_q.hour,
                       minute: req_q.minute, second: req_q.second};
  assign new_rec   = '{id: next_id_q, quantity: req_q.quantity, stamp: req_stamp};

  assign full     = (count_q == CNT_W'(DEPTH));
  assign found    = |match_vec;
  assign bad_rank = (32'(req_q.rank) >= 32'(count_q));

  assign ctl.ins = exec && (req_q.opcode == OP_INSERT) && !full;
  assign ctl.rem = exec && (req_q.opcode == OP_REMOVE) && found;

  // prefix or of the match flags: every slot at or past the first match
  // pulls from its successor
  always_comb begin
    del_vec = match_vec;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      del_vec = del_vec | (del_vec << s);
    end
    first_vec = match_vec & ~(del_vec << 1);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    slot_t prev_s, next_s;
    logic  prev_gt;

    if (g == 0) begin : g_head
      assign prev_s  = '0;
      assign prev_gt = 1'b1;
    end else begin : g_mid
      assign prev_s  = slot[g-1];
      assign prev_gt = gt_vec[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_body
      assign next_s = slot[g+1];
    end

    tsrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cap_i       (accept),
      .tgt_id_i    (req_i.target_id),
      .new_stamp_i (in_stamp),
      .ctl_i       (ctl),
      .prev_gt_i   (prev_gt),
      .del_i       (del_vec[g]),
      .prev_slot_i (prev_s),
      .next_slot_i (next_s),
      .new_rec_i   (new_rec),
      .slot_o      (slot[g]),
      .gt_o        (gt_vec[g]),
      .match_o     (match_vec[g])
    );

    assign occ_vec[g] = slot[g].occ;
  end

  // and-or selection of the removed and the read record
  always_comb begin
    rem_rec = '0;
    rd_rec  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rem_rec = rem_rec | (slot[i].rec & {$bits(rec_t){first_vec[i]}});
      rd_rec  = rd_rec  | (slot[i].rec & {$bits(rec_t){rank_hit_q[i] && slot[i].occ}});
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    count_d = count_q;
    if (ctl.ins) count_d = count_q + CNT_W'(1);
    else if (ctl.rem) count_d = count_q - CNT_W'(1);
  end

  always_comb begin
    res_d             = '0;
    res_d.entry_count = 7'(count_d);
    case (req_q.opcode)
      OP_INSERT: begin
        if (full) begin
          res_d.status = STS_FULL;
        end else begin
          res_d.record_id = next_id_q;
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          res_d.status = STS_NOT_FOUND;
        end else begin
          res_d.record_id       = rem_rec.id;
          res_d.record_quantity = rem_rec.quantity;
        end
      end
      OP_READ: begin
        if (bad_rank) begin
          res_d.status = STS_BAD_RANK;
        end else begin
          res_d.record_id       = rd_rec.id;
          res_d.record_quantity = rd_rec.quantity;
          res_d.record_month    = rd_rec.stamp.month;
          res_d.record_day      = rd_rec.stamp.day;
          res_d.record_hour     = rd_rec.stamp.hour;
          res_d.record_minute   = rd_rec.stamp.minute;
          res_d.record_second   = rd_rec.stamp.second;
        end
      end
      default: begin
        // unused opcode: count only
        res_d.status = STS_OK;
      end
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // ---------------------------------------------------------------- checks
  a_valid_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without an executed request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("record count beyond table depth");

  a_occ_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == 32'(count_q))
    else $error("occupied slots disagree with record count");

  a_full_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.opcode == OP_INSERT) && (count_q == CNT_W'(DEPTH)))
      |=> ##1 (result_o.status == STS_FULL))
    else $error("insert into full table not reported");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for timestamp_sorted_record_table_unit
// drives insert, remove, read and unused-opcode requests with random gaps, tracks the
// table contents in a scoreboard and checks every result field by field
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrt_pkg::*;

  // opcode 3 has no operation behind it, the table must leave it alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned QUIET_LIMIT    = 600;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_REQUESTS = 170;

  // how random requests are weighted within one phase
  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_e;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the table plus the queue of expected results
  // --------------------------------------------------------------------------
  class record_table_scoreboard;
    logic [31:0] held_id    [DEPTH];
    logic [15:0] held_qty   [DEPTH];
    logic [25:0] held_stamp [DEPTH];
    int unsigned held_count;
    logic [31:0] next_id;
    res_t        expected_q [$];
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_id_writes;
    int unsigned n_op     [4];
    int unsigned n_status [4];

    function new();
      held_count  = 0;
      next_id     = '0;
      mismatches  = 0;
      n_checked   = 0;
      n_id_writes = 0;
      for (int i = 0; i < 4; i++) begin
        n_op[i]     = 0;
        n_status[i] = 0;
      end
    endfunction

    function void load_first_id(logic [31:0] value);
      next_id = value;
      n_id_writes++;
    endfunction

    // work out the result of an accepted request and update the mirror
    function void note_request(req_t rq);
      res_t        want;
      stamp_t      found;
      logic [25:0] stamp;
      int unsigned pos;
      int unsigned k;
      want  = '0;
      stamp = {rq.month, rq.day, rq.hour, rq.minute, rq.second};
      n_op[rq.opcode]++;
      case (rq.opcode)
        OP_INSERT: begin
          if (held_count >= DEPTH) begin
            want.status = STS_FULL;
          end else begin
            // newest first, a new record goes ahead of equal stamps
            pos = 0;
            while (pos < held_count && held_stamp[pos] > stamp) pos++;
            for (k = held_count; k > pos; k--) begin
              held_id[k]    = held_id[k-1];
              held_qty[k]   = held_qty[k-1];
              held_stamp[k] = held_stamp[k-1];
            end
            held_id[pos]     = next_id;
            held_qty[pos]    = rq.quantity;
            held_stamp[pos]  = stamp;
            want.record_id   = next_id;
            next_id          = next_id + 32'd1;
            held_count++;
          end
        end
        OP_REMOVE: begin
          pos = 0;
          while (pos < held_count && held_id[pos] != rq.target_id) pos++;
          if (pos >= held_count) begin
            want.status = STS_NOT_FOUND;
          end else begin
            want.record_id       = held_id[pos];
            want.record_quantity = held_qty[pos];
            for (k = pos; k + 1 < held_count; k++) begin
              held_id[k]    = held_id[k+1];
              held_qty[k]   = held_qty[k+1];
              held_stamp[k] = held_stamp[k+1];
            end
            held_count--;
          end
        end
        OP_READ: begin
          if (rq.rank >= held_count) begin
            want.status = STS_BAD_RANK;
          end else begin
            found                = held_stamp[rq.rank];
            want.record_id       = held_id[rq.rank];
            want.record_quantity = held_qty[rq.rank];
            want.record_month    = found.month;
            want.record_day      = found.day;
            want.record_hour     = found.hour;
            want.record_minute   = found.minute;
            want.record_second   = found.second;
          end
        end
        default: ;
      endcase
      want.entry_count = 7'(held_count);
      n_status[want.status]++;
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: result %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, n_checked, what, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding, record_id",
                        got.record_id, '0);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.record_id !== want.record_id)
          report_mismatch("record_id", got.record_id, want.record_id);
        if (got.record_quantity !== want.record_quantity)
          report_mismatch("record_quantity", got.record_quantity, want.record_quantity);
        if (got.record_month !== want.record_month)
          report_mismatch("record_month", got.record_month, want.record_month);
        if (got.record_day !== want.record_day)
          report_mismatch("record_day", got.record_day, want.record_day);
        if (got.record_hour !== want.record_hour)
          report_mismatch("record_hour", got.record_hour, want.record_hour);
        if (got.record_minute !== want.record_minute)
          report_mismatch("record_minute", got.record_minute, want.record_minute);
        if (got.record_second !== want.record_second)
          report_mismatch("record_second", got.record_second, want.record_second);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  req_t        req_i       = '0;
  logic        result_valid_o;
  res_t        result_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  record_table_scoreboard ledger;
  int unsigned            quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  timestamp_sorted_record_table_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge, before the block's
  // own registers move. a result is checked before a request accepted at
  // the same edge is noted, since that result can only belong to an older
  // request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) ledger.load_first_id(cfg_wdata_i);
      if (result_valid_o) ledger.check_result(result_o);
      if (start && !busy) ledger.note_request(req_i);

      // watchdog: a stretch with no accepted request and no result
      if (result_valid_o || (start && !busy) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results still outstanding",
                 $realtime, quiet_cycles, ledger.expected_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drive tasks: each is entered and left at a falling edge
  // --------------------------------------------------------------------------

  // present one request and hold it until the block takes it; start stays
  // high so a following request can go out back to back
  task automatic issue(req_t rq);
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    while (ledger.expected_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  // the id register is only touched with the table idle
  task automatic write_first_id(logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic req_t make_request(logic [1:0] op, logic [31:0] target,
                                        logic [5:0] rank, logic [15:0] qty,
                                        stamp_t stamp);
    req_t rq;
    rq.opcode    = op;
    rq.target_id = target;
    rq.rank      = rank;
    rq.quantity  = qty;
    rq.month     = stamp.month;
    rq.day       = stamp.day;
    rq.hour      = stamp.hour;
    rq.minute    = stamp.minute;
    rq.second    = stamp.second;
    return rq;
  endfunction

  // random request, weighted by the phase mix and aimed at live table
  // contents most of the time
  function automatic req_t random_request(mix_e mix);
    req_t        rq;
    int unsigned w_ins;
    int unsigned w_rem;
    int unsigned w_read;
    int unsigned pick;
    int unsigned roll;
    case (mix)
      MIX_FILL:  begin w_ins = 70; w_rem = 15; w_read = 12; end
      MIX_DRAIN: begin w_ins = 15; w_rem = 70; w_read = 12; end
      default:   begin w_ins = 40; w_rem = 30; w_read = 27; end
    endcase

    // unused fields still carry random bits
    rq.target_id = $urandom();
    rq.rank      = 6'($urandom_range(0, 63));
    rq.quantity  = 16'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 5) rq.quantity = '0;
    else if (roll < 10) rq.quantity = '1;

    // stamps: mostly calendar values, some from a tiny pool so that equal
    // stamps pile up, and some anywhere in the field widths
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      rq.month  = 4'($urandom_range(1, 12));
      rq.day    = 5'($urandom_range(1, 31));
      rq.hour   = 5'($urandom_range(0, 23));
      rq.minute = 6'($urandom_range(0, 59));
      rq.second = 6'($urandom_range(0, 60));
    end else if (roll < 75) begin
      rq.month  = 4'($urandom_range(1, 2));
      rq.day    = 5'($urandom_range(1, 2));
      rq.hour   = '0;
      rq.minute = '0;
      rq.second = 6'($urandom_range(0, 1));
    end else begin
      rq.month  = 4'($urandom_range(0, 15));
      rq.day    = 5'($urandom_range(0, 31));
      rq.hour   = 5'($urandom_range(0, 31));
      rq.minute = 6'($urandom_range(0, 63));
      rq.second = 6'($urandom_range(0, 63));
    end

    pick = $urandom_range(0, 99);
    roll = $urandom_range(0, 99);
    if (pick < w_ins) begin
      rq.opcode = OP_INSERT;
    end else if (pick < w_ins + w_rem) begin
      rq.opcode = OP_REMOVE;
      if (ledger.held_count != 0 && roll < 80)
        rq.target_id = ledger.held_id[$urandom_range(0, ledger.held_count - 1)];
      else if (roll < 90)
        rq.target_id = ledger.next_id - 32'($urandom_range(1, 4));
    end else if (pick < w_ins + w_rem + w_read) begin
      rq.opcode = OP_READ;
      if (ledger.held_count != 0 && roll < 75)
        rq.rank = 6'($urandom_range(0, ledger.held_count - 1));
    end else begin
      rq.opcode = OP_UNUSED;
    end
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    mix_e        mix;
    logic [31:0] id_start;
    int unsigned gap;
    int unsigned roll;
    bit          calm;

    ledger = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table corner cases first
    write_first_id(32'h0000_0000);
    issue(make_request(OP_READ,   '0, 6'd0, '0, '0));
    issue(make_request(OP_REMOVE, '0, '0,   '0, '0));
    issue(make_request(OP_UNUSED, '1, '1,   '1, '1));

    // lowest and highest stamps, a tie with an older insert, a calendar max
    issue(make_request(OP_INSERT, '1, '1, 16'h0000, '0));
    issue(make_request(OP_INSERT, '0, '0, 16'hffff, '1));
    issue(make_request(OP_INSERT, '0, '0, 16'h1234, {4'd6, 5'd15, 5'd12, 6'd30, 6'd30}));
    issue(make_request(OP_INSERT, '0, '0, 16'h0005, {4'd6, 5'd15, 5'd12, 6'd30, 6'd30}));
    issue(make_request(OP_INSERT, '0, '0, 16'h00aa, {4'd12, 5'd31, 5'd23, 6'd59, 6'd60}));

    // walk the ranks, then one far past the count
    for (int r = 0; r < 5; r++) issue(make_request(OP_READ, '0, 6'(r), '0, '0));
    issue(make_request(OP_READ, '0, 6'd63, '0, '0));

    // remove from the middle, then an id that was never given
    issue(make_request(OP_REMOVE, 32'd2,          '0, '0, '0));
    issue(make_request(OP_REMOVE, 32'hffff_ffff,  '0, '0, '0));

    // id counter wraps, and id 0 then exists twice: remove takes the first
    write_first_id(32'hffff_fffe);
    for (int n = 0; n < 3; n++)
      issue(make_request(OP_INSERT, '0, '0, 16'(n + 7), {4'd1, 5'd1, 5'd0, 6'd0, 6'd0}));
    issue(make_request(OP_REMOVE, 32'd0, '0, '0, '0));
    issue(make_request(OP_READ,   '0, 6'd0, '0, '0));
    issue(make_request(OP_READ,   '0, 6'd5, '0, '0));

    // random phases: insert-heavy, remove-heavy and mixed traffic in turn
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       id_start = 32'hffff_ffc0;
        1:       id_start = 32'hffff_ffff;
        2:       id_start = 32'h8000_0000;
        3:       id_start = 32'h7fff_ffff;
        4:       id_start = 32'h0000_0000;
        default: id_start = $urandom();
      endcase
      write_first_id(id_start);

      case (p % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      calm = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        issue(random_request(mix));
        // sender gaps: mostly none or short, now and then a long one
        roll = $urandom_range(0, 99);
        if (calm || roll < 45) gap = 0;
        else if (roll < 85) gap = $urandom_range(1, 3);
        else if (roll < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 40);
        if ($urandom_range(0, 199) == 0) drain();
        else idle(gap);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);

    $display("requests: %0d insert, %0d remove, %0d read, %0d unused opcode; %0d id loads",
             ledger.n_op[OP_INSERT], ledger.n_op[OP_REMOVE], ledger.n_op[OP_READ],
             ledger.n_op[OP_UNUSED], ledger.n_id_writes);
    $display("results: %0d checked, %0d ok, %0d not found, %0d full, %0d bad rank",
             ledger.n_checked, ledger.n_status[STS_OK], ledger.n_status[STS_NOT_FOUND],
             ledger.n_status[STS_FULL], ledger.n_status[STS_BAD_RANK]);
    if (ledger.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/tsrt_pkg.sv
sv/tsrt_cell.sv
sv/timestamp_sorted_record_table_unit.sv
tb/sv/tb.sv
